// ===== sv/sidtoa_pkg.sv =====
// Package: shared types and constants for the signed decimal ASCII converter.
`default_nettype none
package sidtoa_pkg;

	localparam int VALUE_BITS = 16;
	// Decimal digits enough for a magnitude of up to 2**(VALUE_BITS-1).
	localparam int NUM_DIGITS = (VALUE_BITS * 3 + 9) / 10;
	localparam int BCD_W      = NUM_DIGITS * 4;
	localparam int BCNT_W     = $clog2(VALUE_BITS + 1);
	localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [7:0]                   start_pos;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic [7:0] buf_index;
		logic       last;
	} out_beat_t;

	// Converted number handed from the converter to the character emitter.
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic             neg;
		logic [7:0]       pos;
	} conv_res_t;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_RUN,
		CV_DONE
	} conv_state_t;

	typedef enum logic [2:0] {
		EM_IDLE,
		EM_SIGN,
		EM_SKIP,
		EM_DIGIT,
		EM_SPACE,
		EM_NUL
	} emit_state_t;

endpackage
`default_nettype wire

// ===== sv/sidtoa_conv.sv =====
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
`default_nettype none
module sidtoa_conv (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  sidtoa_pkg::in_beat_t  in_data,
	output logic                  res_valid,
	input  wire                   res_take,
	output sidtoa_pkg::conv_res_t res_data
);

	sidtoa_pkg::conv_state_t state_q, state_d;
	logic [sidtoa_pkg::VALUE_BITS-1:0] bin_q;
	logic [sidtoa_pkg::BCD_W-1:0]      bcd_q;
	logic [sidtoa_pkg::BCD_W-1:0]      adj;
	logic [sidtoa_pkg::BCNT_W-1:0]     cnt_q;
	logic                              neg_q;
	logic [7:0]                        pos_q;
	logic [sidtoa_pkg::VALUE_BITS-1:0] raw;
	logic                              accept;
	logic                              last_bit;

	assign raw      = in_data.value;
	assign accept   = in_valid && in_ready;
	assign last_bit = (cnt_q == sidtoa_pkg::BCNT_W'(1));

	// Correct each BCD digit before the shift.
	always_comb begin
		for (int i = 0; i < sidtoa_pkg::NUM_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
			                                          : bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sidtoa_pkg::CV_IDLE: if (in_valid) state_d = sidtoa_pkg::CV_RUN;
			sidtoa_pkg::CV_RUN:  if (last_bit) state_d = sidtoa_pkg::CV_DONE;
			sidtoa_pkg::CV_DONE: if (res_take) state_d = sidtoa_pkg::CV_IDLE;
			default:             state_d = sidtoa_pkg::CV_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == sidtoa_pkg::CV_IDLE);
		res_valid = (state_q == sidtoa_pkg::CV_DONE);
		res_data  = '{bcd: bcd_q, neg: neg_q, pos: pos_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidtoa_pkg::CV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[sidtoa_pkg::VALUE_BITS-1];
			bin_q <= raw[sidtoa_pkg::VALUE_BITS-1] ? (~raw + sidtoa_pkg::VALUE_BITS'(1)) : raw;
			bcd_q <= '0;
			pos_q <= in_data.start_pos;
			cnt_q <= sidtoa_pkg::BCNT_W'(sidtoa_pkg::VALUE_BITS);
		end else if (state_q == sidtoa_pkg::CV_RUN) begin
			bcd_q <= {adj[sidtoa_pkg::BCD_W-2:0], bin_q[sidtoa_pkg::VALUE_BITS-1]};
			bin_q <= {bin_q[sidtoa_pkg::VALUE_BITS-2:0], 1'b0};
			cnt_q <= cnt_q - sidtoa_pkg::BCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// ===== sv/sidtoa_emit.sv =====
// Character emitter: BCD digits go one per unstalled cycle into the output register.
`default_nettype none
module sidtoa_emit (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   res_valid,
	output logic                  res_take,
	input  sidtoa_pkg::conv_res_t res_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output sidtoa_pkg::out_beat_t out_data
);

	sidtoa_pkg::emit_state_t state_q, state_d;
	logic [sidtoa_pkg::BCD_W-1:0]  dig_q;
	logic [sidtoa_pkg::DCNT_W-1:0] cnt_q;
	logic [7:0]                    pos_q;
	logic                          out_valid_q;
	sidtoa_pkg::out_beat_t         out_q;

	logic [3:0]            top_dig;
	logic                  adv;
	logic                  one_left;
	logic                  load_out;
	logic                  shift_dig;
	sidtoa_pkg::out_beat_t out_d;

	assign top_dig  = dig_q[sidtoa_pkg::BCD_W-1 -: 4];
	assign adv      = !out_valid_q || out_ready;
	assign one_left = (cnt_q == sidtoa_pkg::DCNT_W'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			sidtoa_pkg::EM_IDLE:  if (res_valid) state_d = res_data.neg ? sidtoa_pkg::EM_SIGN
			                                                            : sidtoa_pkg::EM_SKIP;
			sidtoa_pkg::EM_SIGN:  if (adv) state_d = sidtoa_pkg::EM_SKIP;
			sidtoa_pkg::EM_SKIP:  if (top_dig != 4'd0 || one_left) state_d = sidtoa_pkg::EM_DIGIT;
			sidtoa_pkg::EM_DIGIT: if (adv && one_left) state_d = sidtoa_pkg::EM_SPACE;
			sidtoa_pkg::EM_SPACE: if (adv) state_d = sidtoa_pkg::EM_NUL;
			sidtoa_pkg::EM_NUL:   if (adv) state_d = sidtoa_pkg::EM_IDLE;
			default:              state_d = sidtoa_pkg::EM_IDLE;
		endcase
	end

	always_comb begin
		res_take  = 1'b0;
		load_out  = 1'b0;
		shift_dig = 1'b0;
		out_d     = '{char_code: sidtoa_pkg::CH_NUL, buf_index: pos_q, last: 1'b0};
		case (state_q)
			sidtoa_pkg::EM_IDLE: begin
				res_take = res_valid;
			end
			sidtoa_pkg::EM_SIGN: begin
				load_out        = adv;
				out_d.char_code = sidtoa_pkg::CH_MINUS;
			end
			sidtoa_pkg::EM_SKIP: begin
				shift_dig = (top_dig == 4'd0) && !one_left;
			end
			sidtoa_pkg::EM_DIGIT: begin
				load_out        = adv;
				shift_dig       = adv;
				out_d.char_code = sidtoa_pkg::CH_ZERO + {4'd0, top_dig};
			end
			sidtoa_pkg::EM_SPACE: begin
				load_out        = adv;
				out_d.char_code = sidtoa_pkg::CH_SPACE;
			end
			sidtoa_pkg::EM_NUL: begin
				load_out   = adv;
				out_d.last = 1'b1;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sidtoa_pkg::EM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			dig_q <= res_data.bcd;
			pos_q <= res_data.pos;
			cnt_q <= sidtoa_pkg::DCNT_W'(sidtoa_pkg::NUM_DIGITS);
		end else begin
			if (shift_dig) begin
				dig_q <= {dig_q[sidtoa_pkg::BCD_W-5:0], 4'd0};
				cnt_q <= cnt_q - sidtoa_pkg::DCNT_W'(1);
			end
			if (load_out) begin
				pos_q <= pos_q + 8'd1;
			end
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// Top level: signed integer to decimal ASCII character stream.
//
//   channel   dir  handshake              beat
//   in_data   in   in_valid / in_ready    value (signed), start_pos
//   out_data  out  out_valid / out_ready  char_code, buf_index, last
//
// Each input beat is accepted, passed through the bit-serial binary to BCD converter and
// handed on as BCD digits. While the output flows the converter sets the rate; character
// emission overlaps the next value.
// One input beat gives 3 to NUM_DIGITS + 3 output beats, the last one marked.
// Reset (arst_n low) empties both stages; no output beat is pending afterwards.
// A stalled output holds its beat; the emitter waits, then the converter waits.
`default_nettype none
module signed_int_to_decimal_ascii_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  sidtoa_pkg::in_beat_t  in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output sidtoa_pkg::out_beat_t out_data
);

	// Converted number waiting for the emitter.
	logic                  res_valid;
	logic                  res_take;
	sidtoa_pkg::conv_res_t res_data;

	// Take the magnitude apart one input bit per cycle.
	sidtoa_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_data  (res_data)
	);

	// Emit a minus sign for a negative value, drop leading zeros, then emit digits, space and terminator.
	sidtoa_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_data  (res_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
